// ----- rtl/core/cts_pkg.sv -----
package cts_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;
  localparam int unsigned STEP_RESET    = 10;
  localparam int unsigned RUN_MAX       = 255;
  localparam int unsigned MAX_RESULTS   = 16;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_TICK     = 3'd1,
    CMD_DISPATCH = 3'd2,
    CMD_ADD      = 3'd3,
    CMD_DELETE   = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    RES_DONE  = 3'd0,
    RES_RUN   = 3'd1,
    RES_NONE  = 3'd2,
    RES_FULL  = 3'd3,
    RES_EMPTY = 3'd4
  } res_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_FULL   = 2'd1,
    ERR_DELETE = 2'd2
  } err_t;

  // One table entry as held in memory
  typedef struct packed {
    logic        valid;
    logic [15:0] handle;
    logic [23:0] delay;
    logic [23:0] period;
    logic [7:0]  runs;
  } entry_t;

endpackage

// ----- rtl/core/cooperative_task_scheduler_table_top.sv -----
// From acceptance to the result, each slot walked passes through ST_READ and ST_EXEC; clear
// and tick walk all TASK_SLOTS entries, dispatch walks them all and passes through ST_DONE
// to mark its final result, add walks up to the first free slot, delete reads and writes
// only the indexed slot, and an out-of-range delete or an unknown command goes to ST_DONE.
// One command at a time; busy drops in the cycle of the final result. The walk is set by
// the read-modify-write of the slot memory, one entry at a time.
// Reset: synchronous, active high; busy drops after a clearing pass over all TASK_SLOTS entries.
// Results appear for one cycle marked by result_valid; the receiver cannot stall.
module cooperative_task_scheduler_table_top
  import cts_pkg::*;
#(
  parameter int unsigned TASK_SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [3:0]  slot_index,
  input  logic [15:0] task_handle,
  input  logic [23:0] start_delay,
  input  logic [23:0] repeat_period,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,
  output logic        result_valid,
  output logic [2:0]  result_kind,
  output logic [4:0]  slot_out,
  output logic [15:0] handle_out,
  output logic [1:0]  error_status,
  output logic        last
);

  localparam int unsigned SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TASK_SLOTS + 1);

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_READ  = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t       state;
  logic [CW-1:0] ptr;
  logic [9:0]   tick_step;
  logic [2:0]   cmd;
  logic [3:0]   idx;
  logic [15:0]  hnd;
  logic [23:0]  dly;
  logic [23:0]  per;
  logic [1:0]   err;
  logic [4:0]   nres;
  logic         hold_v;
  logic [4:0]   hold_slot;
  logic [15:0]  hold_handle;

  entry_t       mem [TASK_SLOTS];
  entry_t       rd;
  logic         we;
  logic [SW-1:0] waddr;
  entry_t       wdata;

  // Slot memory, registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[ptr[SW-1:0]];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) tick_step <= 10'(STEP_RESET);
    else if (cfg_we) tick_step <= cfg_wdata;
  end

  assign busy = (state != ST_IDLE);

  logic         ptr_end;
  logic         del_oob;
  assign ptr_end = (ptr == CW'(TASK_SLOTS - 1));
  assign del_oob = ({1'b0, idx} >= 5'(TASK_SLOTS));

  // Modify step: new entry and result for the slot just read
  entry_t       upd;
  logic         upd_we;
  logic         emit;
  res_t         ekind;
  logic         efin;
  logic [1:0]   err_next;
  always_comb begin
    upd      = rd;
    upd_we   = 1'b0;
    emit     = 1'b0;
    ekind    = RES_DONE;
    efin     = 1'b0;
    err_next = err;
    unique case (cmd)
      CMD_CLEAR: begin
        upd = '0; upd_we = 1'b1; err_next = ERR_NONE;
        if (ptr_end) begin emit = 1'b1; efin = 1'b1; end
      end
      CMD_TICK: begin
        upd_we = rd.valid;
        if (rd.delay == 24'd0) begin
          if (rd.runs != 8'(RUN_MAX)) upd.runs = rd.runs + 8'd1;
          if (rd.period != 24'd0) upd.delay = rd.period;
        end else if (rd.delay > {14'd0, tick_step}) begin
          upd.delay = rd.delay - {14'd0, tick_step};
        end else begin
          upd.delay = 24'd0;
        end
        if (ptr_end) begin emit = 1'b1; efin = 1'b1; end
      end
      CMD_DISPATCH: begin
        if (rd.valid && rd.runs != 8'd0 && nres != 5'(MAX_RESULTS)) begin
          upd_we = 1'b1;
          emit = 1'b1;
          ekind = RES_RUN;
          upd.runs = rd.runs - 8'd1;
          if (rd.period == 24'd0) upd = '0;
        end
        if (ptr_end) efin = 1'b1;
      end
      CMD_ADD: begin
        if (!rd.valid) begin
          upd_we = 1'b1; upd = '{1'b1, hnd, dly, per, 8'd0};
          emit = 1'b1; efin = 1'b1;
        end else if (ptr_end) begin
          emit = 1'b1; efin = 1'b1; ekind = RES_FULL; err_next = ERR_FULL;
        end
      end
      CMD_DELETE: begin
        emit = 1'b1; efin = 1'b1;
        upd = '0; upd_we = 1'b1;
        if (!rd.valid) begin ekind = RES_EMPTY; err_next = ERR_DELETE; end
      end
      default: begin
        emit = 1'b1; efin = 1'b1;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      ptr          <= '0;
      err          <= ERR_NONE;
      result_valid <= 1'b0;
      last         <= 1'b0;
      hold_v       <= 1'b0;
    end else begin
      unique case (state)
        ST_INIT: begin
          result_valid <= 1'b0;
          last         <= 1'b0;
          if (ptr_end) begin state <= ST_IDLE; ptr <= '0; end
          else ptr <= ptr + CW'(1);
        end
        ST_IDLE: begin
          result_valid <= 1'b0;
          last         <= 1'b0;
          if (start) begin
            cmd <= command; idx <= slot_index; hnd <= task_handle;
            dly <= start_delay; per <= repeat_period;
            nres <= '0;
            hold_v <= 1'b0;
            ptr <= (command == CMD_DELETE) ? CW'(slot_index) : '0;
            if (command == CMD_DELETE && {1'b0, slot_index} >= 5'(TASK_SLOTS)) begin
              err <= ERR_DELETE;
              state <= ST_DONE;
            end else if (command == CMD_CLEAR || command == CMD_TICK ||
                         command == CMD_DISPATCH || command == CMD_ADD ||
                         command == CMD_DELETE) begin
              state <= ST_READ;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          result_valid <= 1'b0;
          last         <= 1'b0;
          state        <= ST_EXEC;
        end
        ST_EXEC: begin
          err <= err_next;
          if (emit && cmd == CMD_DISPATCH) begin
            // Pass on the run held back and hold this one until the walk ends
            result_valid <= hold_v;
            last         <= 1'b0;
            result_kind  <= RES_RUN;
            slot_out     <= hold_slot;
            handle_out   <= hold_handle;
            error_status <= err_next;
            hold_v       <= 1'b1;
            hold_slot    <= 5'(ptr);
            hold_handle  <= rd.handle;
            nres         <= nres + 5'd1;
          end else if (emit) begin
            result_valid <= 1'b1;
            last         <= efin;
            result_kind  <= ekind;
            slot_out     <= (ekind == RES_FULL) ? 5'(TASK_SLOTS) :
                            (cmd == CMD_CLEAR || cmd == CMD_TICK) ? 5'd0 : 5'(ptr);
            handle_out   <= 16'd0;
            error_status <= err_next;
          end else begin
            result_valid <= 1'b0;
            last         <= 1'b0;
          end
          if (efin) state <= (cmd == CMD_DISPATCH) ? ST_DONE : ST_IDLE;
          else begin ptr <= ptr + CW'(1); state <= ST_READ; end
        end
        ST_DONE: begin
          result_valid <= 1'b1;
          last         <= 1'b1;
          // Final result: held run, nothing ran, bad delete or plain done
          priority if (cmd == CMD_DISPATCH && hold_v) begin
            result_kind <= RES_RUN;
            slot_out    <= hold_slot;
            handle_out  <= hold_handle;
          end else if (cmd == CMD_DISPATCH) begin
            result_kind <= RES_NONE;
            slot_out    <= 5'd0;
            handle_out  <= 16'd0;
          end else if (cmd == CMD_DELETE && del_oob) begin
            result_kind <= RES_EMPTY;
            slot_out    <= {1'b0, idx};
            handle_out  <= 16'd0;
          end else begin
            result_kind <= RES_DONE;
            slot_out    <= 5'd0;
            handle_out  <= 16'd0;
          end
          error_status <= err;
          state        <= ST_IDLE;
        end
        default: begin
          result_valid <= 1'b0;
          last         <= 1'b0;
          state        <= ST_INIT;
        end
      endcase
    end
  end

  // Write port: clearing pass or write-back
  always_comb begin
    we    = 1'b0;
    waddr = ptr[SW-1:0];
    wdata = upd;
    if (!rst && state == ST_INIT) begin
      we = 1'b1; wdata = '0;
    end else if (!rst && state == ST_EXEC) begin
      we = upd_we;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_has_strobe: assert property (@(posedge clk) disable iff (rst)
    last |-> result_valid) else $error("last without result strobe");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !start) |=> !result_valid)
    else $error("result while idle");
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> !busy) else $error("still busy after final result");
  a_full_err: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind == RES_FULL) |-> error_status == ERR_FULL)
    else $error("full result without error code");
`endif

endmodule
